// ----- hw/rtl/bam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_pkg: shared types and constants of the block-average mosaic
// Register indexes, field widths and the divider job record.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned IdxW   = 12;
  // Wide enough for a full 255 x 255 block of 255-valued pixels
  localparam int unsigned SumW   = 24;
  localparam int unsigned CntW   = 16;
  localparam int unsigned MaxHeight = 4096;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BLOCK  = 2'd2
  } reg_idx_e;

  // One finished block waiting for its means
  typedef struct packed {
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
    logic [SumW-1:0] sum_r;
    logic [SumW-1:0] sum_g;
    logic [SumW-1:0] sum_b;
    logic [SumW-1:0] sum_a;
    logic [CntW-1:0] count;
  } div_job_t;

endpackage

// ----- hw/rtl/bam_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_div: restoring divider for the four channel means
// One quotient bit per cycle for all four channels, saturating at 255.
// ----------------------------------------------------------------------------
module bam_div import bam_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  div_job_t        job_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [IdxW-1:0] col_o,
  output logic [IdxW-1:0] row_o,
  output logic [ChanW-1:0] avg_r_o,
  output logic [ChanW-1:0] avg_g_o,
  output logic [ChanW-1:0] avg_b_o,
  output logic [ChanW-1:0] avg_a_o
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic                busy_q;
  logic [StepW-1:0]    step_q;
  logic [SumW-1:0]     num_q [4];
  logic [SumW-1:0]     quo_q [4];
  logic [CntW-1:0]     den_q;
  logic [SumW+CntW-1:0] rem_q [4];
  logic [IdxW-1:0]     col_q, row_q;
  logic                done_q;

  logic [SumW+CntW-1:0] trial [4];
  logic [ChanW-1:0]     sat [4];

  // Shift one numerator bit into each remainder
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      trial[c] = {rem_q[c][SumW+CntW-2:0], num_q[c][SumW-1]};
      sat[c]   = (|quo_q[c][SumW-1:ChanW]) ? {ChanW{1'b1}} : quo_q[c][ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= StepW'(SumW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Payload path of the divider
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q[0] <= job_i.sum_r;
      num_q[1] <= job_i.sum_g;
      num_q[2] <= job_i.sum_b;
      num_q[3] <= job_i.sum_a;
      for (int c = 0; c < 4; c++) begin
        rem_q[c] <= '0;
        quo_q[c] <= '0;
      end
      den_q <= job_i.count;
      col_q <= job_i.col;
      row_q <= job_i.row;
    end else if (busy_q) begin
      for (int c = 0; c < 4; c++) begin
        num_q[c] <= {num_q[c][SumW-2:0], 1'b0};
        if (trial[c] >= {{SumW{1'b0}}, den_q}) begin
          rem_q[c] <= trial[c] - {{SumW{1'b0}}, den_q};
          quo_q[c] <= {quo_q[c][SumW-2:0], 1'b1};
        end else begin
          rem_q[c] <= trial[c];
          quo_q[c] <= {quo_q[c][SumW-2:0], 1'b0};
        end
      end
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign col_o   = col_q;
  assign row_o   = row_q;
  assign avg_r_o = sat[0];
  assign avg_g_o = sat[1];
  assign avg_b_o = sat[2];
  assign avg_a_o = sat[3];

endmodule

// ----- hw/rtl/block_average_mosaic_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_mosaic_top: block-average pixelation of a raster RGBA stream
//
// Pixels enter on s_axis (tdata = red, green, blue, alpha from bit 0 up) in
// raster order. Width, height and block size are set on the cfg channel
// (index 0, 1, 2), which is ready only between pixels; reset values 640,
// 480, 10. Per block column the channel sums live in one synchronous memory
// of MAX_WIDTH entries: a pixel is read on accept and written back in the
// next cycle, and only then is the next pixel of the stream accepted.
// A finished block goes to a one-entry job slot; the shared bit-serial
// divider takes it once it is idle and its output register is empty.
// It works on one block at a time while the input goes on with the next
// pixels, and its means reach m_axis through that output register.
// A block that ends while the slot is still full holds the input until the
// divider takes the slot. The result (column, row, four means) waits in an
// output register on m_axis until taken, so a stalled receiver stops the
// divider and, once the slot is full, the input.
// Reset clears counters and handshakes; the sum memory is not cleared, as
// each block writes its entry fresh on its first pixel.
// ----------------------------------------------------------------------------
module block_average_mosaic_top import bam_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_BLOCK = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // red, green, blue, alpha
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // block_column, block_row, avg_red, avg_green, avg_blue, avg_alpha
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned OffW  = $clog2(MAX_BLOCK);
  localparam int unsigned MemW  = 4 * SumW;

  typedef enum logic [1:0] { ST_IDLE, ST_READ, ST_WRITE, ST_WAIT } state_e;

  logic [12:0] width_q, height_q;
  logic [7:0]  bsize_q;

  state_e            state_q;
  logic [12:0]       pcol_q, bcol_q;
  logic [IdxW-1:0]   prow_q, brow_q;
  logic [OffW-1:0]   offx_q, offy_q;
  logic [31:0]       pix_q;
  logic [MemW-1:0]   mem [MAX_WIDTH];
  logic [MemW-1:0]   rd_q;
  logic [AddrW-1:0]  addr_q;
  logic              job_pend_q;
  div_job_t          job_q;
  logic              m_valid_q;
  logic [63:0]       m_data_q;

  // Clamped limits
  logic [12:0] w_c, h_c;
  logic [8:0]  bs_c;
  always_comb begin
    w_c = (width_q == '0) ? 13'd1 :
          (32'(width_q) > MAX_WIDTH) ? 13'(MAX_WIDTH) : width_q;
    h_c = (height_q == '0) ? 13'd1 :
          (32'(height_q) > MaxHeight) ? 13'(MaxHeight) : height_q;
    bs_c = (bsize_q == '0) ? 9'd1 :
           (32'(bsize_q) > MAX_BLOCK) ? 9'(MAX_BLOCK) : {1'b0, bsize_q};
  end

  logic row_end, col_end, bex, bey, first, blk_end;
  logic [SumW-1:0] s [4];
  logic [MemW-1:0] wr_d;
  logic [AddrW-1:0] idx_c;
  always_comb begin
    row_end = pcol_q >= w_c - 13'd1;
    col_end = 13'(prow_q) >= h_c - 13'd1;
    bex     = row_end || (9'(offx_q) >= bs_c - 9'd1);
    bey     = col_end || (9'(offy_q) >= bs_c - 9'd1);
    blk_end = bex && bey;
    first   = (offx_q == '0) && (offy_q == '0);
    idx_c   = (32'(bcol_q) >= MAX_WIDTH) ? AddrW'(MAX_WIDTH - 1) : AddrW'(bcol_q);
    for (int c = 0; c < 4; c++) begin
      s[c] = (first ? '0 : rd_q[c*SumW +: SumW]) + SumW'(pix_q[c*8 +: 8]);
    end
    wr_d = {s[3], s[2], s[1], s[0]};
  end

  logic div_busy, div_done, div_go, adv, job_load;
  logic [IdxW-1:0] d_col, d_row;
  logic [ChanW-1:0] d_r, d_g, d_b, d_a;

  // Hand the slot to the divider only when its result cannot be overwritten
  assign div_go   = job_pend_q && !m_valid_q && !div_done && !div_busy;
  assign job_load = (state_q == ST_WAIT) && !job_pend_q;
  assign adv      = ((state_q == ST_READ) && !blk_end) || job_load;

  bam_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_go),
    .job_i   (job_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .col_o   (d_col), .row_o (d_row),
    .avg_r_o (d_r), .avg_g_o (d_g), .avg_b_o (d_b), .avg_a_o (d_a)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      bsize_q  <= 8'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_BLOCK:  bsize_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sum memory: read on accept, write back in the next cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      rd_q   <= mem[idx_c];
      addr_q <= idx_c;
      pix_q  <= s_axis_tdata;
    end
    if (state_q == ST_READ) mem[addr_q] <= wr_d;
    // Load the finished block once the job slot is free
    if (job_load) begin
      job_q.col   <= bcol_q[IdxW-1:0];
      job_q.row   <= brow_q;
      job_q.sum_r <= s[0];
      job_q.sum_g <= s[1];
      job_q.sum_b <= s[2];
      job_q.sum_a <= s[3];
      job_q.count <= CntW'((32'(offx_q) + 1) * (32'(offy_q) + 1));
    end
    if (div_done) m_data_q <= {8'd0, d_a, d_b, d_g, d_r, d_row, d_col};
  end

  // Sequencer, counters and handshakes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pcol_q <= '0; prow_q <= '0; bcol_q <= '0; brow_q <= '0;
      offx_q <= '0; offy_q <= '0;
      job_pend_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (job_load) job_pend_q <= 1'b1;
      else if (div_go) job_pend_q <= 1'b0;
      if (div_done) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) state_q <= ST_READ;
        ST_READ: begin
          if (blk_end) begin
            state_q <= ST_WAIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          // queue the finished block once the slot frees up
          if (!job_pend_q) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      // Advance the raster position once the pixel is fully handled
      if (adv) begin
        if (row_end) begin
          pcol_q <= '0; offx_q <= '0; bcol_q <= '0;
          if (col_end) begin
            prow_q <= '0; offy_q <= '0; brow_q <= '0;
          end else begin
            prow_q <= prow_q + 1'b1;
            if (9'(offy_q) >= bs_c - 9'd1) begin
              offy_q <= '0; brow_q <= brow_q + 1'b1;
            end else offy_q <= offy_q + 1'b1;
          end
        end else begin
          pcol_q <= pcol_q + 1'b1;
          if (9'(offx_q) >= bs_c - 9'd1) begin
            offx_q <= '0; bcol_q <= bcol_q + 1'b1;
          end else offx_q <= offx_q + 1'b1;
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the block-average mosaic
// Streams RGBA frames under several width, height and block size settings,
// predicts each finished block's indices and truncated means, and compares
// every output item in order, with and without random source and sink stalls.
// ----------------------------------------------------------------------------
module tb import bam_pkg::*; ();

  localparam int unsigned MaxW = 4096;
  localparam int unsigned MaxB = 128;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic [11:0] row;
    logic [11:0] col;
  } mosaic_block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  block_average_mosaic_top uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  int unsigned img_w, img_h, blk;
  int unsigned sr[MaxW], sg[MaxW], sb[MaxW], sa[MaxW];
  int unsigned px_col, px_row, off_x, off_y, bcol, brow;

  mosaic_block_t block_q[$];
  int unsigned   src_idle, snk_idle;
  int            errors = 0;
  int            n_pix = 0;
  int            n_blocks = 0;

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] mean_of(int unsigned s, int unsigned c);
    int unsigned q;
    q = s / c;
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  // Advance the mosaic model by one pixel; queue a block when it closes
  function automatic void predict_pixel(logic [31:0] px);
    int unsigned w, h, bs, i, cnt;
    bit row_end, col_end;
    mosaic_block_t e;
    w = clampv(img_w, MaxW);
    h = clampv(img_h, MaxHeight);
    bs = clampv(blk, MaxB);
    i = (bcol >= MaxW) ? MaxW - 1 : bcol;
    if (off_x == 0 && off_y == 0) begin
      sr[i] = px[7:0]; sg[i] = px[15:8]; sb[i] = px[23:16]; sa[i] = px[31:24];
    end else begin
      sr[i] += px[7:0]; sg[i] += px[15:8]; sb[i] += px[23:16]; sa[i] += px[31:24];
    end
    row_end = px_col >= w - 1;
    col_end = px_row >= h - 1;
    if ((row_end || off_x >= bs - 1) && (col_end || off_y >= bs - 1)) begin
      cnt = (off_x + 1) * (off_y + 1);
      e.col = bcol[11:0];
      e.row = brow[11:0];
      e.r = mean_of(sr[i], cnt);
      e.g = mean_of(sg[i], cnt);
      e.b = mean_of(sb[i], cnt);
      e.a = mean_of(sa[i], cnt);
      block_q.push_back(e);
    end
    if (row_end) begin
      px_col = 0; off_x = 0; bcol = 0;
      if (col_end) begin
        px_row = 0; off_y = 0; brow = 0;
      end else begin
        px_row++;
        if (off_y >= bs - 1) begin
          off_y = 0; brow++;
        end else begin
          off_y++;
        end
      end
    end else begin
      px_col++;
      if (off_x >= bs - 1) begin
        off_x = 0; bcol++;
      end else begin
        off_x++;
      end
    end
  endfunction

  // Send one pixel with random source gaps; valid stays up for the next one
  task automatic send_pixel(logic [31:0] px);
    while (src_idle != 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(px);
    n_pix++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait until every block came out, then let the divider drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (block_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WIDTH:  img_w = val;
      REG_HEIGHT: img_h = val;
      default:    blk = val[7:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned bs);
    drain();
    write_reg(REG_WIDTH, w[12:0]);
    write_reg(REG_HEIGHT, h[12:0]);
    write_reg(REG_BLOCK, bs[12:0]);
  endtask

  function automatic logic [31:0] rand_pixel();
    return $urandom;
  endfunction

  task automatic send_frame(int unsigned w, int unsigned h);
    repeat (w * h) send_pixel(rand_pixel());
  endtask

  // Directed: extreme channel values, pass-through, partial edges
  task automatic test_directed();
    set_frame(3, 2, 1);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA55A_5AA5);
    send_pixel(32'h5AA5_A55A);
    send_pixel(32'h8001_7FFE);
    send_pixel(32'h0102_0408);
    // Full white block, then partial blocks at the right and bottom edges
    set_frame(5, 3, 2);
    repeat (15) send_pixel(32'hFFFF_FFFF);
  endtask

  // Single-pixel frame and zero registers behaving as 1
  task automatic test_small_regs();
    set_frame(1, 1, 1);
    send_pixel(32'h1234_5678);
    set_frame(0, 0, 0);
    send_pixel(32'hFEDC_BA98);
    send_pixel(rand_pixel());
  endtask

  // Largest block: one tall narrow frame, then a wide short row
  task automatic test_large_block();
    set_frame(3, 130, 128);
    send_frame(3, 130);
    set_frame(300, 1, 255);
    send_frame(300, 1);
  endtask

  // Random frames, mostly small
  task automatic test_random(int unsigned n_items);
    int unsigned w, h, bs, sent;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 12);
      bs = $urandom_range(1, 6);
      if ($urandom_range(9) == 0) bs = $urandom_range(1, 255);
      set_frame(w, h, bs);
      send_frame(w, h);
      sent += w * h;
    end
  endtask

  // Check each output block against the oldest prediction
  always @(posedge clk_i) begin
    mosaic_block_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[55:0];
      n_blocks++;
      if (block_q.size() == 0) begin
        $display("%0t: unexpected block %h", $time, got);
        errors++;
      end else begin
        want = block_q.pop_front();
        if (got.col !== want.col) begin
          $display("%0t: block_column exp %0d got %0d", $time, want.col, got.col);
          errors++;
        end
        if (got.row !== want.row) begin
          $display("%0t: block_row exp %0d got %0d", $time, want.row, got.row);
          errors++;
        end
        if (got.r !== want.r) begin
          $display("%0t: avg_red exp %0d got %0d", $time, want.r, got.r);
          errors++;
        end
        if (got.g !== want.g) begin
          $display("%0t: avg_green exp %0d got %0d", $time, want.g, got.g);
          errors++;
        end
        if (got.b !== want.b) begin
          $display("%0t: avg_blue exp %0d got %0d", $time, want.b, got.b);
          errors++;
        end
        if (got.a !== want.a) begin
          $display("%0t: avg_alpha exp %0d got %0d", $time, want.a, got.a);
          errors++;
        end
      end
    end
  end

  // Sink stalls
  always @(negedge clk_i) begin
    m_axis_tready <= !(snk_idle != 0 && $urandom_range(99) < snk_idle);
  end

  initial begin
    img_w = 640; img_h = 480; blk = 10;
    px_col = 0; px_row = 0; off_x = 0; off_y = 0; bcol = 0; brow = 0;
    src_idle = 31; snk_idle = 66;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_small_regs();
    test_large_block();
    test_random(200);
    src_idle = 66; snk_idle = 31;
    test_random(200);
    src_idle = 0; snk_idle = 0;
    test_random(200);
    drain();
    if (block_q.size() != 0) begin
      $display("%0d blocks never arrived", block_q.size());
      errors++;
    end
    $display("Sent %0d pixels over many frame geometries; checked %0d blocks.",
             n_pix, n_blocks);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/bam_pkg.sv
hw/rtl/bam_div.sv
hw/rtl/block_average_mosaic_top.sv
tb/sv/tb.sv
